// ----- rtl/psa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types and codes for the page-span allocator.
// ----------------------------------------------------------------------------
package psa_pkg;

    localparam int ADDR_W    = 40;
    localparam int CNT_W     = 8;
    localparam int CMD_W     = 2;
    localparam int ST_W      = 2;
    localparam int CHUNK_W   = 6;
    localparam int TDATA_W   = 56;
    localparam int REG_IDX_W = 1;
    localparam int OP_W      = 5;

    localparam logic [CHUNK_W-1:0] POOL_CHUNKS_RST = 6'd32;

    localparam logic [REG_IDX_W-1:0] REG_POOL_BASE   = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_POOL_CHUNKS = 1'd1;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_OOM       = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_SIZE  = 2'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

    // Datapath operations; the controller state is one of these.
    localparam logic [OP_W-1:0] OP_IDLE     = 5'd0;
    localparam logic [OP_W-1:0] OP_DISPATCH = 5'd1;
    localparam logic [OP_W-1:0] OP_SCAN     = 5'd2;
    localparam logic [OP_W-1:0] OP_CV_LEN   = 5'd3;
    localparam logic [OP_W-1:0] OP_MAP      = 5'd4;
    localparam logic [OP_W-1:0] OP_TK_RD    = 5'd5;
    localparam logic [OP_W-1:0] OP_TK_S     = 5'd6;
    localparam logic [OP_W-1:0] OP_TK_REM   = 5'd7;
    localparam logic [OP_W-1:0] OP_TK_OWN   = 5'd8;
    localparam logic [OP_W-1:0] OP_RM_RD    = 5'd9;
    localparam logic [OP_W-1:0] OP_RM_WR    = 5'd10;
    localparam logic [OP_W-1:0] OP_PU_RD    = 5'd11;
    localparam logic [OP_W-1:0] OP_PU_WR1   = 5'd12;
    localparam logic [OP_W-1:0] OP_PU_WR2   = 5'd13;
    localparam logic [OP_W-1:0] OP_RL_RD    = 5'd14;
    localparam logic [OP_W-1:0] OP_RL_CK    = 5'd15;
    localparam logic [OP_W-1:0] OP_BK_TEST  = 5'd16;
    localparam logic [OP_W-1:0] OP_BK_Q     = 5'd17;
    localparam logic [OP_W-1:0] OP_BK_CK    = 5'd18;
    localparam logic [OP_W-1:0] OP_FW_TEST  = 5'd19;
    localparam logic [OP_W-1:0] OP_FW_Q     = 5'd20;
    localparam logic [OP_W-1:0] OP_FW_CK    = 5'd21;
    localparam logic [OP_W-1:0] OP_RL_FIN   = 5'd22;
    localparam logic [OP_W-1:0] OP_LK_RD    = 5'd23;
    localparam logic [OP_W-1:0] OP_LK_Q     = 5'd24;
    localparam logic [OP_W-1:0] OP_LK_CK    = 5'd25;
    localparam logic [OP_W-1:0] OP_FIN      = 5'd26;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [ST_W-1:0] st;
    } psa_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd_code;
        logic             k_bad;
        logic             in_range;
        logic             ne_hit;
        logic             i_max;
        logic             can_carve;
        logic             split;
        logic             rel_ok;
        logic             s_zero;
        logic             fw_can;
        logic             mrg_ok;
        logic             use_hit;
        logic             m_last;
        logic             out_free;
    } psa_stat_t;

endpackage

// ----- rtl/psa_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_datapath
// Page map, span tables, free-list links, bucket heads and result register.
// ----------------------------------------------------------------------------
module psa_datapath import psa_pkg::*; #(
    parameter int MAX_SPAN_PAGES = 128,
    parameter int POOL_PAGES     = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_addr,
    input  logic [ADDR_W-1:0]    cfg_wdata,
    input  logic                 s_tvalid,
    input  logic [TDATA_W-1:0]   s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,
    input  psa_cmd_t             cmd,
    output psa_stat_t            stat
);

    localparam int IW    = $clog2(POOL_PAGES);
    localparam int VW    = $clog2(POOL_PAGES + 1);
    localparam int NW    = IW + 1;
    localparam int BW    = $clog2(MAX_SPAN_PAGES + 1);
    localparam int CAP   = POOL_PAGES / MAX_SPAN_PAGES;
    localparam int CW    = $clog2(CAP + 1);
    localparam int CMP_W = (CW > CHUNK_W) ? CW : CHUNK_W;

    logic [VW-1:0] owner_mem [POOL_PAGES];
    logic [BW-1:0] len_mem   [POOL_PAGES];
    logic          use_mem   [POOL_PAGES];
    logic [VW-1:0] next_mem  [POOL_PAGES];
    logic [VW-1:0] prev_mem  [POOL_PAGES];
    logic [VW-1:0] head_mem  [MAX_SPAN_PAGES + 1];

    logic [VW-1:0] own_rd_reg, nx_rd_reg, pv_rd_reg, hd_rd_reg;
    logic [BW-1:0] len_rd_reg;
    logic          use_rd_reg;

    logic [ADDR_W-1:0]  base_reg;
    logic [CHUNK_W-1:0] pchunks_reg;
    logic [CW-1:0]      chunks_reg;
    logic [VW-1:0]      fill_reg;
    logic [MAX_SPAN_PAGES:0] ne_reg;

    logic [CMD_W-1:0]  cmd_reg;
    logic [CNT_W-1:0]  k_reg;
    logic [ADDR_W-1:0] loc_reg;
    logic [BW-1:0]     i_reg, b_reg, len_reg, m_reg, mlen_reg;
    logic [IW-1:0]     s_reg, x_reg, q_reg;
    logic [VW-1:0]     h_reg;

    logic              m_tvalid_reg;
    logic [ST_W-1:0]   status_reg;
    logic [ADDR_W-1:0] start_reg;
    logic [CNT_W-1:0]  pages_reg;

    logic [IW-1:0] own_ra, lu_ra, lk_ra, own_wa, lu_wa, nx_wa, pv_wa;
    logic [BW-1:0] hd_ra, hd_wa, len_wd;
    logic [VW-1:0] own_wd, nx_wd, pv_wd, hd_wd;
    logic          own_we, lu_we, nx_we, pv_we, hd_we, use_wd;

    logic [IW-1:0] lin, q_next;
    logic [BW-1:0] kb;
    logic [VW-1:0] x_p1, h_cur;
    logic [NW-1:0] n_sum;
    logic [BW:0]   len_sum;
    logic          out_free;

    assign lin     = loc_reg[IW-1:0];
    assign kb      = k_reg[BW-1:0];
    assign q_next  = IW'(own_rd_reg - VW'(1));
    assign x_p1    = VW'(x_reg) + VW'(1);
    assign h_cur   = ne_reg[b_reg] ? hd_rd_reg : '0;
    assign n_sum   = NW'(s_reg) + NW'(len_reg);
    assign len_sum = (BW+1)'(len_rd_reg) + (BW+1)'(len_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    assign stat.cmd_code  = cmd_reg;
    assign stat.k_bad     = (k_reg == '0) || (k_reg > CNT_W'(MAX_SPAN_PAGES));
    assign stat.in_range  = loc_reg < ADDR_W'(fill_reg);
    assign stat.ne_hit    = ne_reg[i_reg];
    assign stat.i_max     = i_reg == BW'(MAX_SPAN_PAGES);
    assign stat.can_carve = (CMP_W'(chunks_reg) < CMP_W'(CAP))
                            && (CMP_W'(chunks_reg) < CMP_W'(pchunks_reg));
    assign stat.split     = i_reg > kb;
    assign stat.rel_ok    = (own_rd_reg == VW'(lin) + VW'(1)) && use_rd_reg;
    assign stat.s_zero    = s_reg == '0;
    assign stat.fw_can    = n_sum < NW'(fill_reg);
    assign stat.mrg_ok    = !use_rd_reg && (len_sum <= (BW+1)'(MAX_SPAN_PAGES));
    assign stat.use_hit   = use_rd_reg;
    assign stat.m_last    = m_reg == mlen_reg - BW'(1);
    assign stat.out_free  = out_free;

    // memory port steering
    always_comb begin
        own_ra = '0; lu_ra = '0; lk_ra = '0; hd_ra = '0;
        own_we = 1'b0; own_wa = '0; own_wd = '0;
        lu_we = 1'b0; lu_wa = '0; len_wd = '0; use_wd = 1'b0;
        nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
        pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
        hd_we = 1'b0; hd_wa = '0; hd_wd = '0;
        case (cmd.op)
            OP_RL_RD: begin
                own_ra = lin;
                lu_ra  = lin;
            end
            OP_LK_RD:   own_ra = lin;
            OP_BK_TEST: own_ra = s_reg - IW'(1);
            OP_FW_TEST: own_ra = n_sum[IW-1:0];
            OP_BK_Q, OP_FW_Q, OP_LK_Q: lu_ra = q_next;
            OP_RM_RD:   lk_ra = x_reg;
            OP_TK_RD:   hd_ra = i_reg;
            OP_PU_RD:   hd_ra = b_reg;
            OP_MAP: begin
                own_we = 1'b1;
                own_wa = x_reg + IW'(m_reg);
                own_wd = x_p1;
            end
            OP_CV_LEN: begin
                lu_we  = 1'b1;
                lu_wa  = fill_reg[IW-1:0];
                len_wd = BW'(MAX_SPAN_PAGES);
            end
            OP_TK_REM: begin
                lu_we  = 1'b1;
                lu_wa  = s_reg + IW'(kb);
                len_wd = i_reg - kb;
            end
            OP_TK_OWN: begin
                lu_we  = 1'b1;
                lu_wa  = s_reg;
                len_wd = kb;
                use_wd = 1'b1;
            end
            OP_RL_FIN: begin
                lu_we  = 1'b1;
                lu_wa  = s_reg;
                len_wd = len_reg;
            end
            OP_RM_WR: begin
                if (pv_rd_reg != '0) begin
                    nx_we = 1'b1;
                    nx_wa = IW'(pv_rd_reg - VW'(1));
                    nx_wd = nx_rd_reg;
                end else begin
                    hd_we = 1'b1;
                    hd_wa = b_reg;
                    hd_wd = nx_rd_reg;
                end
                if (nx_rd_reg != '0) begin
                    pv_we = 1'b1;
                    pv_wa = IW'(nx_rd_reg - VW'(1));
                    pv_wd = pv_rd_reg;
                end
            end
            OP_PU_WR1: begin
                nx_we = 1'b1;
                nx_wa = x_reg;
                nx_wd = h_cur;
                pv_we = 1'b1;
                pv_wa = x_reg;
                hd_we = 1'b1;
                hd_wa = b_reg;
                hd_wd = x_p1;
            end
            OP_PU_WR2: begin
                if (h_reg != '0) begin
                    pv_we = 1'b1;
                    pv_wa = IW'(h_reg - VW'(1));
                    pv_wd = x_p1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (own_we) owner_mem[own_wa] <= own_wd;
        own_rd_reg <= owner_mem[own_ra];
    end

    always_ff @(posedge aclk) begin
        if (lu_we) begin
            len_mem[lu_wa] <= len_wd;
            use_mem[lu_wa] <= use_wd;
        end
        len_rd_reg <= len_mem[lu_ra];
        use_rd_reg <= use_mem[lu_ra];
    end

    always_ff @(posedge aclk) begin
        if (nx_we) next_mem[nx_wa] <= nx_wd;
        nx_rd_reg <= next_mem[lk_ra];
    end

    always_ff @(posedge aclk) begin
        if (pv_we) prev_mem[pv_wa] <= pv_wd;
        pv_rd_reg <= prev_mem[lk_ra];
    end

    always_ff @(posedge aclk) begin
        if (hd_we) head_mem[hd_wa] <= hd_wd;
        hd_rd_reg <= head_mem[hd_ra];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg     <= '0;
            pchunks_reg  <= POOL_CHUNKS_RST;
            chunks_reg   <= '0;
            fill_reg     <= '0;
            ne_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_POOL_BASE:   base_reg    <= cfg_wdata;
                    REG_POOL_CHUNKS: pchunks_reg <= cfg_wdata[CHUNK_W-1:0];
                    default: ;
                endcase
            end
            if (hd_we) ne_reg[hd_wa] <= (hd_wd != '0);
            if (cmd.op == OP_CV_LEN) begin
                chunks_reg <= chunks_reg + CW'(1);
                fill_reg   <= fill_reg + VW'(MAX_SPAN_PAGES);
            end
            if (cmd.op == OP_FIN && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_IDLE: begin
                if (s_tvalid) begin
                    cmd_reg <= s_tdata[CMD_W-1:0];
                    k_reg   <= s_tdata[CMD_W+CNT_W-1:CMD_W];
                    loc_reg <= s_tdata[CMD_W+CNT_W+ADDR_W-1:CMD_W+CNT_W] - base_reg;
                end
            end
            OP_DISPATCH: i_reg <= kb;
            OP_SCAN: begin
                if (!stat.ne_hit && !stat.i_max) i_reg <= i_reg + BW'(1);
            end
            OP_CV_LEN: begin
                x_reg    <= fill_reg[IW-1:0];
                m_reg    <= '0;
                mlen_reg <= BW'(MAX_SPAN_PAGES);
                b_reg    <= BW'(MAX_SPAN_PAGES);
                i_reg    <= BW'(MAX_SPAN_PAGES);
            end
            OP_MAP: m_reg <= m_reg + BW'(1);
            OP_TK_S: begin
                s_reg <= IW'(hd_rd_reg - VW'(1));
                x_reg <= IW'(hd_rd_reg - VW'(1));
                b_reg <= i_reg;
            end
            OP_TK_REM: begin
                x_reg    <= s_reg + IW'(kb);
                m_reg    <= '0;
                mlen_reg <= i_reg - kb;
                b_reg    <= i_reg - kb;
            end
            OP_TK_OWN: begin
                x_reg    <= s_reg;
                m_reg    <= '0;
                mlen_reg <= kb;
                len_reg  <= kb;
            end
            OP_PU_WR1: h_reg <= h_cur;
            OP_RL_CK: begin
                s_reg   <= lin;
                len_reg <= len_rd_reg;
            end
            OP_BK_Q, OP_FW_Q, OP_LK_Q: q_reg <= q_next;
            OP_BK_CK: begin
                if (stat.mrg_ok) begin
                    b_reg   <= len_rd_reg;
                    x_reg   <= q_reg;
                    s_reg   <= q_reg;
                    len_reg <= len_sum[BW-1:0];
                end
            end
            OP_FW_CK: begin
                if (stat.mrg_ok) begin
                    b_reg   <= len_rd_reg;
                    x_reg   <= q_reg;
                    len_reg <= len_sum[BW-1:0];
                end
            end
            OP_RL_FIN: begin
                x_reg    <= s_reg;
                m_reg    <= '0;
                mlen_reg <= len_reg;
                b_reg    <= len_reg;
            end
            OP_LK_CK: begin
                s_reg   <= q_reg;
                len_reg <= len_rd_reg;
            end
            OP_FIN: begin
                if (out_free) begin
                    status_reg <= cmd.st;
                    start_reg  <= (cmd.st == ST_OK) ? base_reg + ADDR_W'(s_reg) : '0;
                    pages_reg  <= (cmd.st == ST_OK) ? CNT_W'(len_reg) : '0;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(TDATA_W-ST_W-ADDR_W-CNT_W)'(0), pages_reg, start_reg, status_reg};

endmodule

// ----- rtl/psa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_ctrl
// Sequencer for allocate, release and lookup; drives one datapath op a cycle.
// ----------------------------------------------------------------------------
module psa_ctrl import psa_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  psa_stat_t stat,
    output psa_cmd_t  cmd
);

    localparam logic [2:0] CX_TAKE  = 3'd0;
    localparam logic [2:0] CX_CARVE = 3'd1;
    localparam logic [2:0] CX_SPLIT = 3'd2;
    localparam logic [2:0] CX_ALLOC = 3'd3;
    localparam logic [2:0] CX_BACK  = 3'd4;
    localparam logic [2:0] CX_FWD   = 3'd5;
    localparam logic [2:0] CX_REL   = 3'd6;

    logic [OP_W-1:0] state_reg, state_next;
    logic [2:0]      ctx_reg, ctx_next;
    logic [ST_W-1:0] st_reg, st_next;

    always_comb begin
        state_next = state_reg;
        ctx_next   = ctx_reg;
        st_next    = st_reg;
        case (state_reg)
            OP_IDLE: begin
                if (s_tvalid) state_next = OP_DISPATCH;
            end
            OP_DISPATCH: begin
                state_next = OP_FIN;
                st_next    = ST_NOT_FOUND;
                case (stat.cmd_code)
                    CMD_ALLOC: begin
                        if (stat.k_bad) st_next = ST_BAD_SIZE;
                        else state_next = OP_SCAN;
                    end
                    CMD_RELEASE: begin
                        if (stat.in_range) state_next = OP_RL_RD;
                    end
                    CMD_LOOKUP: begin
                        if (stat.in_range) state_next = OP_LK_RD;
                    end
                    default: ;
                endcase
            end
            OP_SCAN: begin
                if (stat.ne_hit) begin
                    state_next = OP_TK_RD;
                    ctx_next   = CX_TAKE;
                end else if (stat.i_max) begin
                    if (stat.can_carve) begin
                        state_next = OP_CV_LEN;
                        ctx_next   = CX_CARVE;
                    end else begin
                        state_next = OP_FIN;
                        st_next    = ST_OOM;
                    end
                end
            end
            OP_CV_LEN, OP_TK_REM, OP_TK_OWN: state_next = OP_MAP;
            OP_MAP: begin
                if (stat.m_last) begin
                    if (ctx_reg == CX_ALLOC) begin
                        state_next = OP_FIN;
                        st_next    = ST_OK;
                    end else begin
                        state_next = OP_PU_RD;
                    end
                end
            end
            OP_PU_RD:  state_next = OP_PU_WR1;
            OP_PU_WR1: state_next = OP_PU_WR2;
            OP_PU_WR2: begin
                case (ctx_reg)
                    CX_CARVE: begin
                        state_next = OP_TK_RD;
                        ctx_next   = CX_TAKE;
                    end
                    CX_SPLIT: begin
                        state_next = OP_TK_OWN;
                        ctx_next   = CX_ALLOC;
                    end
                    default: begin
                        state_next = OP_FIN;
                        st_next    = ST_OK;
                    end
                endcase
            end
            OP_TK_RD: state_next = OP_TK_S;
            OP_TK_S:  state_next = OP_RM_RD;
            OP_RM_RD: state_next = OP_RM_WR;
            OP_RM_WR: begin
                case (ctx_reg)
                    CX_TAKE: begin
                        if (stat.split) begin
                            state_next = OP_TK_REM;
                            ctx_next   = CX_SPLIT;
                        end else begin
                            state_next = OP_TK_OWN;
                            ctx_next   = CX_ALLOC;
                        end
                    end
                    CX_BACK: state_next = OP_BK_TEST;
                    default: state_next = OP_FW_TEST;
                endcase
            end
            OP_RL_RD: state_next = OP_RL_CK;
            OP_RL_CK: begin
                if (stat.rel_ok) begin
                    state_next = OP_BK_TEST;
                end else begin
                    state_next = OP_FIN;
                    st_next    = ST_NOT_FOUND;
                end
            end
            OP_BK_TEST: state_next = stat.s_zero ? OP_FW_TEST : OP_BK_Q;
            OP_BK_Q:    state_next = OP_BK_CK;
            OP_BK_CK: begin
                if (stat.mrg_ok) begin
                    state_next = OP_RM_RD;
                    ctx_next   = CX_BACK;
                end else begin
                    state_next = OP_FW_TEST;
                end
            end
            OP_FW_TEST: state_next = stat.fw_can ? OP_FW_Q : OP_RL_FIN;
            OP_FW_Q:    state_next = OP_FW_CK;
            OP_FW_CK: begin
                if (stat.mrg_ok) begin
                    state_next = OP_RM_RD;
                    ctx_next   = CX_FWD;
                end else begin
                    state_next = OP_RL_FIN;
                end
            end
            OP_RL_FIN: begin
                state_next = OP_MAP;
                ctx_next   = CX_REL;
            end
            OP_LK_RD: state_next = OP_LK_Q;
            OP_LK_Q:  state_next = OP_LK_CK;
            OP_LK_CK: begin
                state_next = OP_FIN;
                st_next    = stat.use_hit ? ST_OK : ST_NOT_FOUND;
            end
            OP_FIN: begin
                if (stat.out_free) state_next = OP_IDLE;
            end
            default: state_next = OP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= OP_IDLE;
            ctx_reg   <= CX_TAKE;
        end else begin
            state_reg <= state_next;
            ctx_reg   <= ctx_next;
        end
    end

    always_ff @(posedge aclk) begin
        st_reg <= st_next;
    end

    assign cmd.op = state_reg;
    assign cmd.st = st_reg;

endmodule

// ----- rtl/page_span_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_span_allocator
// Page-span allocator with per-length LIFO free lists, carving, and coalescing.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  cmd, page_count, page_number
//  m_       out  m_tvalid/m_tready  status, span_start, span_pages
//  cfg_     in   cfg_wr_en          pool_base_page, pool_chunks
//
//  One item at a time; an allocate may scan buckets, carve a chunk and split.
//  Bucket scan visits one bucket a cycle and the page map takes one page
//  write a cycle on its single write port.
//  Reset clears bucket valid bits and the carved-page count; no clearing pass.
//  A new item is taken while the previous result waits in the output register.
// ----------------------------------------------------------------------------
module page_span_allocator import psa_pkg::*; #(
    parameter int MAX_SPAN_PAGES = 128,
    parameter int POOL_PAGES     = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_addr,
    input  logic [ADDR_W-1:0]    cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // cmd, page_count, page_number
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata    // status, span_start, span_pages
);

    psa_cmd_t  cmd;
    psa_stat_t stat;

    psa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    psa_datapath #(
        .MAX_SPAN_PAGES (MAX_SPAN_PAGES),
        .POOL_PAGES     (POOL_PAGES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

    assign s_tready = (cmd.op == OP_IDLE);

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[ST_W-1:0] != ST_OK)
        |-> m_tdata[ST_W+ADDR_W+CNT_W-1:ST_W] == '0)
        else $error("error result carries span data");

    a_ok_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[ST_W-1:0] == ST_OK)
        |-> (m_tdata[ST_W+ADDR_W+CNT_W-1:ST_W+ADDR_W] != '0)
            && (m_tdata[ST_W+ADDR_W+CNT_W-1:ST_W+ADDR_W] <= CNT_W'(MAX_SPAN_PAGES)))
        else $error("span length out of range");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for page_span_allocator. A span-heap model in the
// bench predicts every response; directed tests cover size errors, pool
// exhaustion, bad and double releases, lookups of free or foreign pages and
// address wrap, then random allocate/release/lookup traffic runs under
// three backpressure profiles with pool register changes in between.
// ----------------------------------------------------------------------------
module tb;
    import psa_pkg::*;

    localparam int SPAN_MAX = 128;
    localparam int NPAGES   = 4096;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [ST_W-1:0]   st;
        logic [ADDR_W-1:0] start;
        logic [CNT_W-1:0]  pages;
    } span_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0] cfg_addr = '0;
    logic [ADDR_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata = '0;   // cmd, page_count, page_number
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;        // status, span_start, span_pages

    page_span_allocator dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // allocator state: owner, links and heads hold index + 1, 0 is none
    int unsigned owner [NPAGES];
    int unsigned slen  [NPAGES];
    bit          sused [NPAGES];
    int unsigned nxt   [NPAGES];
    int unsigned prv   [NPAGES];
    int unsigned head  [SPAN_MAX+1];
    int unsigned chunks_used;
    logic [ADDR_W-1:0]  pool_base;
    logic [CHUNK_W-1:0] pool_chunks;

    span_result_t expected_q[$];
    int           live_spans[$];
    int           send_idle_pct, recv_idle_pct;
    int           errors, n_items, n_results, n_ok, n_oom, n_bad, n_nf;

    function automatic void list_push(int b, int s);
        int unsigned h;
        h = head[b];
        prv[s] = 0;
        nxt[s] = h;
        if (h != 0) prv[h-1] = s + 1;
        head[b] = s + 1;
    endfunction

    function automatic void list_remove(int b, int s);
        int unsigned p, n;
        p = prv[s];
        n = nxt[s];
        if (p != 0) nxt[p-1] = n;
        else head[b] = n;
        if (n != 0) prv[n-1] = p;
    endfunction

    function automatic void map_pages(int s, int n);
        for (int i = 0; i < n && s + i < NPAGES; i++) owner[s+i] = s + 1;
    endfunction

    function automatic bit take_span(int k, output int start);
        int s, r;
        start = 0;
        for (int i = k; i <= SPAN_MAX; i++) begin
            if (head[i] != 0) begin
                s = head[i] - 1;
                list_remove(i, s);
                if (i > k) begin
                    r = s + k;
                    slen[r] = i - k;
                    sused[r] = 0;
                    map_pages(r, i - k);
                    list_push(i - k, r);
                end
                slen[s] = k;
                sused[s] = 1;
                map_pages(s, k);
                start = s;
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic span_result_t predict_span(logic [CMD_W-1:0] cmd, logic [CNT_W-1:0] k,
                                                  logic [ADDR_W-1:0] pn);
        span_result_t r;
        logic [ADDR_W-1:0] loc;
        int cap, s, n, q, lq, total, c;
        r = '0;
        r.st = ST_NOT_FOUND;
        s = 0;
        total = 0;
        loc = pn - pool_base;
        if (cmd == CMD_ALLOC) begin
            if (k == 0 || k > SPAN_MAX) begin
                r.st = ST_BAD_SIZE;
            end else begin
                cap = NPAGES / SPAN_MAX;
                if (pool_chunks < cap) cap = pool_chunks;
                if (take_span(k, s)) begin
                    r.st = ST_OK;
                    total = k;
                end else if (chunks_used < cap) begin
                    c = chunks_used * SPAN_MAX;
                    slen[c] = SPAN_MAX;
                    sused[c] = 0;
                    map_pages(c, SPAN_MAX);
                    list_push(SPAN_MAX, c);
                    chunks_used++;
                    if (take_span(k, s)) begin
                        r.st = ST_OK;
                        total = k;
                    end else begin
                        r.st = ST_OOM;
                    end
                end else begin
                    r.st = ST_OOM;
                end
                if (r.st == ST_OK) live_spans.push_back(s);
            end
        end else if (cmd == CMD_RELEASE) begin
            if (loc < NPAGES && owner[loc] == loc + 1 && sused[loc]) begin
                s = int'(loc);
                foreach (live_spans[i]) if (live_spans[i] == s) begin
                    live_spans.delete(i);
                    break;
                end
                total = slen[s];
                while (s > 0 && owner[s-1] != 0) begin
                    q = owner[s-1] - 1;
                    lq = slen[q];
                    if (sused[q] || lq + total > SPAN_MAX) break;
                    list_remove(lq, q);
                    s = q;
                    total += lq;
                end
                n = s + total;
                while (n < NPAGES && owner[n] != 0) begin
                    q = owner[n] - 1;
                    lq = slen[q];
                    if (sused[q] || lq + total > SPAN_MAX) break;
                    list_remove(lq, q);
                    total += lq;
                    n = s + total;
                end
                slen[s] = total;
                sused[s] = 0;
                map_pages(s, total);
                list_push(total, s);
                r.st = ST_OK;
            end
        end else if (cmd == CMD_LOOKUP) begin
            if (loc < NPAGES && owner[loc] != 0) begin
                q = owner[loc] - 1;
                if (sused[q]) begin
                    r.st = ST_OK;
                    s = q;
                    total = slen[q];
                end
            end
        end
        if (r.st == ST_OK) begin
            r.start = pool_base + ADDR_W'(s);
            r.pages = CNT_W'(total);
        end
        return r;
    endfunction

    task automatic send_item(logic [CMD_W-1:0] cmd, logic [CNT_W-1:0] k,
                             logic [ADDR_W-1:0] pn);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_tdata = {6'd0, pn, k, cmd};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected_q.push_back(predict_span(cmd, k, pn));
        n_items++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
        wait_drained();
        cfg_wr_en = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val;
        if (idx == REG_POOL_BASE) pool_base = val;
        else pool_chunks = val[CHUNK_W-1:0];
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    function automatic logic [ADDR_W-1:0] live_page(bit start_only);
        int s;
        s = live_spans[$urandom_range(live_spans.size() - 1)];
        if (start_only) return pool_base + ADDR_W'(s);
        return pool_base + ADDR_W'(s) + ADDR_W'($urandom_range(slen[s] - 1));
    endfunction

    always @(negedge aclk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin
        span_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[1:0], m_tdata[41:2], m_tdata[49:42]};
            n_results++;
            if (expected_q.size() == 0) begin
                $error("unexpected item: status %0d start %0h pages %0d",
                       got.st, got.start, got.pages);
                errors++;
            end else begin
                want = expected_q[0];
                expected_q.delete(0);
                case (want.st)
                    ST_OK:       n_ok++;
                    ST_OOM:      n_oom++;
                    ST_BAD_SIZE: n_bad++;
                    default:     n_nf++;
                endcase
                if (got.st != want.st) begin
                    $error("status: expected %0d, got %0d", want.st, got.st);
                    errors++;
                end
                if (got.start != want.start) begin
                    $error("span_start: expected %0h, got %0h", want.start, got.start);
                    errors++;
                end
                if (got.pages != want.pages) begin
                    $error("span_pages: expected %0d, got %0d", want.pages, got.pages);
                    errors++;
                end
            end
        end
    end

    task automatic test_bad_requests();
        send_item(CMD_ALLOC, 8'd0, '0);
        send_item(CMD_ALLOC, 8'd129, '0);
        send_item(CMD_ALLOC, 8'd255, '1);
        send_item(CMD_UNUSED, 8'hFF, '1);
        send_item(CMD_RELEASE, 8'd0, 40'd5);
        send_item(CMD_LOOKUP, 8'd0, 40'd0);
        send_item(CMD_LOOKUP, 8'd0, 40'hFF_FFFF_FFFF);
    endtask

    task automatic test_span_lifecycle();
        send_item(CMD_ALLOC, 8'd128, '0);
        send_item(CMD_ALLOC, 8'd1, '0);
        send_item(CMD_ALLOC, 8'd3, '0);
        send_item(CMD_LOOKUP, 8'd0, 40'd127);
        send_item(CMD_LOOKUP, 8'd0, 40'd130);
        send_item(CMD_RELEASE, 8'd0, 40'd129);
        send_item(CMD_LOOKUP, 8'd0, 40'd129);
        send_item(CMD_RELEASE, 8'd0, 40'd129);
        send_item(CMD_RELEASE, 8'd0, 40'd130);
        send_item(CMD_RELEASE, 8'd0, 40'd128);
        send_item(CMD_RELEASE, 8'd0, 40'd1);
        send_item(CMD_RELEASE, 8'd0, 40'd0);
    endtask

    task automatic test_pool_limits();
        write_reg(REG_POOL_CHUNKS, 40'd0);
        repeat (4) send_item(CMD_ALLOC, 8'd128, '0);
        write_reg(REG_POOL_BASE, 40'hFF_FFFF_FF00);
        write_reg(REG_POOL_CHUNKS, 40'd63);
        send_item(CMD_ALLOC, 8'd128, '0);
        send_item(CMD_ALLOC, 8'd128, '0);
        send_item(CMD_LOOKUP, 8'd0, 40'h00_0000_0010);
        send_item(CMD_LOOKUP, 8'd0, 40'hFF_FFFF_FEFF);
    endtask

    task automatic test_random_traffic(int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 45 && live_spans.size() < 80 || live_spans.size() == 0) begin
                r = $urandom_range(99);
                if (r < 70) begin
                    send_item(CMD_ALLOC, CNT_W'($urandom_range(1, 16)), ADDR_W'($urandom));
                end else if (r < 94) begin
                    send_item(CMD_ALLOC, CNT_W'($urandom_range(1, 128)), ADDR_W'($urandom));
                end else begin
                    send_item(CMD_ALLOC,
                              $urandom_range(0, 1) ? 8'd0 : CNT_W'($urandom_range(129, 255)),
                              ADDR_W'({$urandom, $urandom}));
                end
            end else if (r < 80) begin
                send_item(CMD_RELEASE, CNT_W'($urandom), live_page(1));
            end else if (r < 85) begin
                send_item($urandom_range(0, 1) ? CMD_RELEASE : CMD_UNUSED, CNT_W'($urandom),
                          pool_base + ADDR_W'($urandom_range(NPAGES + 50)));
            end else if (r < 95) begin
                send_item(CMD_LOOKUP, CNT_W'($urandom), live_page(0));
            end else begin
                send_item(CMD_LOOKUP, CNT_W'($urandom),
                          $urandom_range(1) ? ADDR_W'({$urandom, $urandom})
                                            : pool_base + ADDR_W'($urandom_range(NPAGES)));
            end
            if (i == count / 2) wait_drained();
        end
    endtask

    initial begin
        foreach (owner[i]) owner[i] = 0;
        foreach (head[i]) head[i] = 0;
        chunks_used = 0;
        pool_base = '0;
        pool_chunks = POOL_CHUNKS_RST;
        send_idle_pct = 11;
        recv_idle_pct = 67;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_bad_requests();
        test_span_lifecycle();
        test_pool_limits();

        write_reg(REG_POOL_BASE, 40'h12_3456_7000);
        write_reg(REG_POOL_CHUNKS, 40'd32);
        test_random_traffic(330);
        send_idle_pct = 67;
        recv_idle_pct = 11;
        write_reg(REG_POOL_BASE, 40'd0);
        write_reg(REG_POOL_CHUNKS, 40'd5);
        test_random_traffic(330);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_POOL_BASE, 40'h80_0000_0001);
        write_reg(REG_POOL_CHUNKS, 40'd63);
        test_random_traffic(340);

        wait_drained();
        repeat (500) @(posedge aclk);
        $display("Sent %0d items, checked %0d results (ok %0d, out of memory %0d,",
                 n_items, n_results, n_ok, n_oom);
        $display("  bad size %0d, not found %0d); %0d chunks carved.", n_bad, n_nf, chunks_used);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
